FILE: rtl/submatrix_search_core_defines.svh
// Assertion macros for the submatrix search core.
`ifndef SUBMATRIX_SEARCH_CORE_DEFINES_SVH
`define SUBMATRIX_SEARCH_CORE_DEFINES_SVH

`ifndef SYNTH
`define SSC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SSC_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define SSC_ASSERT(lbl, prop, msg)
`define SSC_NEVER(lbl, expr, msg)
`endif

`endif

FILE: rtl/ssc_pkg.sv
// Shared types, codes and helpers for the submatrix search core.
package ssc_pkg;

    localparam int ELEM_W = 32;
    localparam int SIZE_W = 10;

    localparam logic [1:0] OP_LOAD_MATRIX  = 2'd0;
    localparam logic [1:0] OP_LOAD_PATTERN = 2'd1;
    localparam logic [1:0] OP_SEARCH       = 2'd2;

    localparam logic [1:0] REG_MATRIX_ROWS  = 2'd0;
    localparam logic [1:0] REG_MATRIX_COLS  = 2'd1;
    localparam logic [1:0] REG_PATTERN_ROWS = 2'd2;
    localparam logic [1:0] REG_PATTERN_COLS = 2'd3;

    typedef logic [ELEM_W-1:0] elem_t;

    typedef struct packed {
        logic shift;
        logic pat_we;
    } cell_ctrl_t;

    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                     input logic [SIZE_W-1:0] maxv);
        logic [SIZE_W-1:0] r;
        r = v;
        if (v == '0)
            r = {{(SIZE_W-1){1'b0}}, 1'b1};
        else if (v > maxv)
            r = maxv;
        return r;
    endfunction

endpackage

FILE: rtl/ssc_cell.sv
// One compare cell: holds a pattern column and one window element of the stream.
module ssc_cell #(
    parameter int PROWS = 4,
    parameter int PRIW  = 2
) (
    input  logic                  clk,
    input  ssc_pkg::cell_ctrl_t   ctrl,
    input  logic                  inject,
    input  logic [PRIW-1:0]       pat_wrow,
    input  ssc_pkg::elem_t        pat_wdata,
    input  logic [PRIW-1:0]       rd_row,
    input  ssc_pkg::elem_t        feed_data,
    input  ssc_pkg::elem_t        nbr_data,
    output ssc_pkg::elem_t        data,
    output logic                  eq
);
    import ssc_pkg::*;

    elem_t pat_reg [PROWS];
    elem_t data_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.pat_we)
            pat_reg[pat_wrow] <= pat_wdata;
        // take the fresh element at the entry cell, else the right neighbor's
        if (ctrl.shift)
            data_reg <= inject ? feed_data : nbr_data;
    end

    assign data = data_reg;
    assign eq   = (data_reg == pat_reg[rd_row]);

endmodule

FILE: rtl/submatrix_search_core.sv
// Submatrix search core: load beats write one matrix or pattern element and
// never raise busy. A search beat holds busy high while every matrix row
// under every candidate top row streams once through a chain of compare cells
// from the single read port of the matrix memory, one element a cycle; a search
// whose pattern does not fit never raises busy. The result is a one-cycle
// done strobe with found; it is never held, so the receiver must take it in
// that cycle.
module submatrix_search_core #(
    parameter int MAX_ROWS         = 16,
    parameter int MAX_COLS         = 16,
    parameter int MAX_PATTERN_ROWS = 4,
    parameter int MAX_PATTERN_COLS = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  op,
    input  logic [3:0]  row_index,
    input  logic [3:0]  col_index,
    input  logic signed [31:0] element,
    output logic        done,
    output logic        found
);
    import ssc_pkg::*;

    `include "submatrix_search_core_defines.svh"

    localparam int RIW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CIW   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int PRIW  = (MAX_PATTERN_ROWS > 1) ? $clog2(MAX_PATTERN_ROWS) : 1;
    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_RUN   = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;

    // configuration registers
    logic [4:0] matrix_rows_reg, matrix_cols_reg;
    logic [2:0] pattern_rows_reg, pattern_cols_reg;
    logic       cfg_we;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            matrix_rows_reg  <= 5'd16;
            matrix_cols_reg  <= 5'd16;
            pattern_rows_reg <= 3'd1;
            pattern_cols_reg <= 3'd1;
        end
        else if (cfg_we)
        begin
            unique case (paddr[3:2])
                REG_MATRIX_ROWS:  matrix_rows_reg  <= pwdata[4:0];
                REG_MATRIX_COLS:  matrix_cols_reg  <= pwdata[4:0];
                REG_PATTERN_ROWS: pattern_rows_reg <= pwdata[2:0];
                REG_PATTERN_COLS: pattern_cols_reg <= pwdata[2:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_MATRIX_ROWS:  prdata = {27'b0, matrix_rows_reg};
            REG_MATRIX_COLS:  prdata = {27'b0, matrix_cols_reg};
            REG_PATTERN_ROWS: prdata = {29'b0, pattern_rows_reg};
            REG_PATTERN_COLS: prdata = {29'b0, pattern_cols_reg};
            default:          prdata = '0;
        endcase
    end

    // accepted beat decode
    logic accept, do_mload, do_pload, do_search;
    assign accept    = start && !busy;
    assign do_mload  = accept && (op == OP_LOAD_MATRIX)
                       && (int'(row_index) < MAX_ROWS) && (int'(col_index) < MAX_COLS);
    assign do_pload  = accept && (op == OP_LOAD_PATTERN)
                       && (int'(row_index) < MAX_PATTERN_ROWS)
                       && (int'(col_index) < MAX_PATTERN_COLS);
    assign do_search = accept && (op == OP_SEARCH);

    // clamped sizes at search start
    logic [SIZE_W-1:0] mr, mc, pr, pc;
    logic              too_big;
    assign mr = clamp_size(SIZE_W'(matrix_rows_reg), SIZE_W'(MAX_ROWS));
    assign mc = clamp_size(SIZE_W'(matrix_cols_reg), SIZE_W'(MAX_COLS));
    assign pr = clamp_size(SIZE_W'(pattern_rows_reg), SIZE_W'(MAX_PATTERN_ROWS));
    assign pc = clamp_size(SIZE_W'(pattern_cols_reg), SIZE_W'(MAX_PATTERN_COLS));
    assign too_big = (pr > mr) || (pc > mc);

    logic [1:0]        state_reg, state_next;
    logic [RIW-1:0]    top_reg, top_last_reg;
    logic [PRIW-1:0]   prow_reg, prow_last_reg;
    logic [CIW-1:0]    col_reg, col_last_reg;
    logic [SIZE_W-1:0] pc_last_reg;

    logic last_col, last_prow, last_top, issue;
    assign issue     = (state_reg == S_RUN);
    assign last_col  = (col_reg == col_last_reg);
    assign last_prow = (prow_reg == prow_last_reg);
    assign last_top  = (top_reg == top_last_reg);

    // read/tag pipeline: stage 1 is memory data, stage 2 is the cell row
    logic            v1_reg, v2_reg;
    logic [PRIW-1:0] r1_reg, r2_reg;
    logic [CIW-1:0]  c1_reg, c2_reg;
    logic            found_acc_reg;
    logic            done_reg, found_out_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (do_search && !too_big) state_next = S_RUN;
            S_RUN:   if (last_col && last_prow && last_top) state_next = S_DRAIN;
            S_DRAIN: if (!v1_reg && !v2_reg) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    assign busy = (state_reg != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            v1_reg    <= issue;
            v2_reg    <= v1_reg;
            done_reg  <= (do_search && too_big)
                         || ((state_reg == S_DRAIN) && !v1_reg && !v2_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_search)
        begin
            top_reg       <= '0;
            prow_reg      <= '0;
            col_reg       <= '0;
            top_last_reg  <= RIW'(mr - pr);
            prow_last_reg <= PRIW'(pr - SIZE_W'(1));
            col_last_reg  <= CIW'(mc - SIZE_W'(1));
            pc_last_reg   <= pc - SIZE_W'(1);
        end
        else if (issue)
        begin
            // advance column, then pattern row, then top row
            if (last_col)
            begin
                col_reg <= '0;
                if (last_prow)
                begin
                    prow_reg <= '0;
                    top_reg  <= top_reg + RIW'(1);
                end
                else
                    prow_reg <= prow_reg + PRIW'(1);
            end
            else
                col_reg <= col_reg + CIW'(1);
        end
        r1_reg <= prow_reg;
        c1_reg <= col_reg;
        r2_reg <= r1_reg;
        c2_reg <= c1_reg;
    end

    // matrix memory
    elem_t             mem [DEPTH];
    elem_t             mem_q;
    logic [AW-1:0]     waddr, raddr;
    logic [SIZE_W-1:0] row_sum;

    assign waddr   = AW'(AW'(row_index) * AW'(MAX_COLS) + AW'(col_index));
    assign row_sum = SIZE_W'(top_reg) + SIZE_W'(prow_reg);
    assign raddr   = AW'(AW'(row_sum) * AW'(MAX_COLS) + AW'(col_reg));

    always_ff @(posedge clk)
    begin
        if (do_mload)
            mem[waddr] <= elem_t'(element);
        if (issue)
            mem_q <= mem[raddr];
    end

    // chain of compare cells; the entry cell is the last pattern column
    elem_t                     cell_data [MAX_PATTERN_COLS];
    logic [MAX_PATTERN_COLS-1:0] cell_eq, cell_mask;

    genvar j;
    generate
        for (j = 0; j < MAX_PATTERN_COLS; j++)
        begin : g_cell
            cell_ctrl_t ctrl;
            elem_t      nbr;
            assign ctrl.shift  = v1_reg;
            assign ctrl.pat_we = do_pload && (int'(col_index) == j);
            assign cell_mask[j] = (SIZE_W'(j) <= pc_last_reg);
            if (j == MAX_PATTERN_COLS - 1)
            begin : g_end
                assign nbr = '0;
            end
            else
            begin : g_mid
                assign nbr = cell_data[j+1];
            end
            ssc_cell #(
                .PROWS (MAX_PATTERN_ROWS),
                .PRIW  (PRIW)
            ) u_cell (
                .clk       (clk),
                .ctrl      (ctrl),
                .inject    (SIZE_W'(j) == pc_last_reg),
                .pat_wrow  (PRIW'(row_index)),
                .pat_wdata (elem_t'(element)),
                .rd_row    (r2_reg),
                .feed_data (mem_q),
                .nbr_data  (nbr),
                .data      (cell_data[j]),
                .eq        (cell_eq[j])
            );
        end
    endgenerate

    // per-left-position row match accumulation
    logic [MAX_COLS-1:0] match_vec_reg;
    logic [SIZE_W-1:0]   left_w;
    logic [CIW-1:0]      left;
    logic                window_ok, row_ok, cur_ok;

    assign window_ok = v2_reg && (SIZE_W'(c2_reg) >= pc_last_reg);
    assign left_w    = SIZE_W'(c2_reg) - pc_last_reg;
    assign left      = left_w[CIW-1:0];
    assign row_ok    = &(cell_eq | ~cell_mask);
    assign cur_ok    = row_ok && ((r2_reg == '0) || match_vec_reg[left]);

    always_ff @(posedge clk)
    begin
        if (window_ok)
            match_vec_reg[left] <= cur_ok;
        if (do_search)
            found_acc_reg <= 1'b0;
        else if (window_ok && cur_ok && (r2_reg == prow_last_reg))
            found_acc_reg <= 1'b1;
        if (do_search && too_big)
            found_out_reg <= 1'b0;
        else if (state_reg == S_DRAIN)
            found_out_reg <= found_acc_reg;
    end

    assign done  = done_reg;
    assign found = found_out_reg;

    `SSC_ASSERT(a_done_idle, done_reg |-> (state_reg == S_IDLE), "result while busy")
    `SSC_ASSERT(a_v2_follows, v2_reg |-> $past(v1_reg), "cell stage without read")
    `SSC_ASSERT(a_busy_cause, $rose(busy) |-> $past(start && op == OP_SEARCH),
                "busy without search")
    `SSC_NEVER(a_issue_drain, v1_reg && (state_reg == S_IDLE), "read in flight when idle")

endmodule
